// ----- sv/third_order_extended_state_observer_core_defines.svh -----
// Assertion macros shared by the observer core files.
`ifndef THIRD_ORDER_EXTENDED_STATE_OBSERVER_CORE_DEFINES_SVH
`define THIRD_ORDER_EXTENDED_STATE_OBSERVER_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TOESO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define TOESO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/toeso_pkg.sv -----
package toeso_pkg;

	localparam int DIG        = 4;
	localparam int MUL_AW     = 49;
	localparam int MUL_BW     = 60;
	localparam int MUL_PW     = MUL_AW + MUL_BW;
	localparam int SUM_W      = MUL_AW + DIG;
	localparam int CFG_DATA_W = 47;

	localparam int STEPS_GAIN = (20 + DIG - 1) / DIG;
	localparam int STEPS_G1   = (22 + DIG - 1) / DIG;
	localparam int STEPS_G2   = (42 + DIG - 1) / DIG;
	localparam int STEPS_G3   = (60 + DIG - 1) / DIG;
	localparam int STEPS_BU   = (32 + DIG - 1) / DIG;
	localparam int STEPS_DT   = (24 + DIG - 1) / DIG;

	localparam int SH_GAIN = MUL_BW - DIG * STEPS_GAIN;
	localparam int SH_G1   = MUL_BW - DIG * STEPS_G1 + 8;
	localparam int SH_G2   = MUL_BW - DIG * STEPS_G2 + 16;
	localparam int SH_G3   = MUL_BW - DIG * STEPS_G3 + 24;
	localparam int SH_BU   = MUL_BW - DIG * STEPS_BU + 8;
	localparam int SH_DT   = MUL_BW - DIG * STEPS_DT + 24;

	localparam int Q_W   = MUL_PW - SH_G3;
	localparam int CNT_W = $clog2(STEPS_G3);

	localparam logic [1:0] CFG_BANDWIDTH  = 2'd0;
	localparam logic [1:0] CFG_PLANT_GAIN = 2'd1;
	localparam logic [1:0] CFG_DIST_LIMIT = 2'd2;

	localparam logic [19:0]        BW_RST = 20'd25600;
	localparam logic signed [31:0] PG_RST = 32'sd65536;
	localparam logic [21:0]        G1_RST = 22'd76800;
	localparam logic [41:0]        G2_RST = 42'd1966080000;
	localparam logic [59:0]        G3_RST = 60'd16777216000000;

	localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

	typedef enum logic [2:0] {
		MOP_GAIN,
		MOP_G1,
		MOP_G2,
		MOP_G3,
		MOP_BU,
		MOP_DT
	} mul_op_t;

	typedef struct packed {
		logic              start;
		mul_op_t           op;
		logic              neg;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic signed [47:0] prod;
		logic [MUL_BW-1:0] raw;
	} mul_rsp_t;

	typedef struct packed {
		logic               op;
		logic signed [31:0] measurement;
		logic signed [31:0] drive;
		logic [23:0]        elapsed_time;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] estimated_output;
		logic signed [47:0] estimated_rate;
		logic signed [47:0] estimated_disturbance;
		logic               updated;
	} out_item_t;

	function automatic logic [CNT_W-1:0] op_last_step(mul_op_t op);
		logic [CNT_W-1:0] n;
		unique case (op)
			MOP_GAIN: n = CNT_W'(STEPS_GAIN - 1);
			MOP_G1:   n = CNT_W'(STEPS_G1 - 1);
			MOP_G2:   n = CNT_W'(STEPS_G2 - 1);
			MOP_G3:   n = CNT_W'(STEPS_G3 - 1);
			MOP_BU:   n = CNT_W'(STEPS_BU - 1);
			MOP_DT:   n = CNT_W'(STEPS_DT - 1);
			default:  n = '0;
		endcase
		return n;
	endfunction

endpackage

// ----- sv/toeso_mul.sv -----
`include "third_order_extended_state_observer_core_defines.svh"

module toeso_mul
	import toeso_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam logic [Q_W-1:0] LIM_NEG = {{(Q_W - 48){1'b0}}, 1'b1, 47'b0};
	localparam logic [Q_W-1:0] LIM_POS = {{(Q_W - 47){1'b0}}, {47{1'b1}}};

	logic [MUL_PW-1:0]  p_q;
	logic [MUL_AW-1:0]  a_q;
	mul_op_t            op_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic signed [47:0] prod_q;
	logic [MUL_BW-1:0]  raw_q;

	logic [SUM_W-1:0]   sum;
	logic [Q_W-1:0]     q;
	logic [Q_W-1:0]     qc;
	logic               sticky;
	logic signed [47:0] prod;

	assign sum = {{DIG{1'b0}}, p_q[MUL_PW-1:MUL_BW]} + SUM_W'(a_q) * SUM_W'(p_q[DIG-1:0]);

	always_comb begin
		q      = '0;
		sticky = 1'b0;
		unique case (op_q)
			MOP_GAIN: begin
				q      = Q_W'(p_q >> SH_GAIN);
				sticky = |p_q[SH_GAIN-1:0];
			end
			MOP_G1: begin
				q      = Q_W'(p_q >> SH_G1);
				sticky = |p_q[SH_G1-1:0];
			end
			MOP_G2: begin
				q      = Q_W'(p_q >> SH_G2);
				sticky = |p_q[SH_G2-1:0];
			end
			MOP_G3: begin
				q      = Q_W'(p_q >> SH_G3);
				sticky = |p_q[SH_G3-1:0];
			end
			MOP_BU: begin
				q      = Q_W'(p_q >> SH_BU);
				sticky = |p_q[SH_BU-1:0];
			end
			MOP_DT: begin
				q      = Q_W'(p_q >> SH_DT);
				sticky = |p_q[SH_DT-1:0];
			end
			default: begin
				q      = '0;
				sticky = 1'b0;
			end
		endcase
		qc = q + Q_W'(neg_q & sticky);
		if (neg_q) begin
			prod = (qc > LIM_NEG) ? S48_MIN : -$signed(qc[47:0]);
		end else begin
			prod = (qc > LIM_POS) ? S48_MAX : $signed(qc[47:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			a_q    <= '0;
			op_q   <= MOP_GAIN;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			prod_q <= '0;
			raw_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (req.start) begin
				p_q    <= {{MUL_AW{1'b0}}, req.b};
				a_q    <= req.a;
				op_q   <= req.op;
				neg_q  <= req.neg;
				cnt_q  <= op_last_step(req.op);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				p_q <= {sum, p_q[MUL_BW-1:DIG]};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (fin_q) begin
				prod_q <= prod;
				raw_q  <= p_q[SH_GAIN +: MUL_BW];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;
	assign rsp.raw  = raw_q;

	`TOESO_ASSERT_NOW(a_start_idle, req.start, !busy_q && !fin_q, "multiply started while busy")
	`TOESO_ASSERT_NEXT(a_fin_done, fin_q, done_q && !fin_q, "finish did not raise done once")
	`TOESO_ASSERT_NEXT(a_count_down, busy_q && !req.start && cnt_q != '0, busy_q && cnt_q == $past(cnt_q) - 1'b1, "digit counter skipped")

endmodule

// ----- sv/third_order_extended_state_observer_core.sv -----
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   in_item_t
// result    out        result_valid / result_stall out_item_t
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An update request runs seven products in turn through one multiplier that consumes four
// bits of its second operand a cycle.
// Clear and zero-time requests skip the multiplier and go straight to the output step.
// A bandwidth write holds the block busy while the gains are rebuilt.
// Reset clears the estimates and loads the register and gain defaults.
// A stalled result holds in its register; the next request is taken meanwhile.
`include "third_order_extended_state_observer_core_defines.svh"

module third_order_extended_state_observer_core
	import toeso_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_GSQ   = 13'b0000000000010,
		S_GCUBE = 13'b0000000000100,
		S_ERR   = 13'b0000000001000,
		S_MG1   = 13'b0000000010000,
		S_MG2   = 13'b0000000100000,
		S_MBU   = 13'b0000001000000,
		S_MG3   = 13'b0000010000000,
		S_MD1   = 13'b0000100000000,
		S_MD2   = 13'b0001000000000,
		S_MD3   = 13'b0010000000000,
		S_CLAMP = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] SUM_MIN = 50'sh3_8000_0000_0000;

	function automatic logic signed [49:0] sx50(logic signed [47:0] v);
		return {{2{v[47]}}, v};
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [49:0] x);
		if (x > SUM_MAX) return S48_MAX;
		if (x < SUM_MIN) return S48_MIN;
		return x[47:0];
	endfunction

	function automatic logic [47:0] mag48(logic signed [47:0] v);
		return v[47] ? (48'd0 - v) : v;
	endfunction

	function automatic mul_req_t mk_req(mul_op_t op, logic [MUL_AW-1:0] a,
			logic [MUL_BW-1:0] b, logic neg);
		mul_req_t r;
		r.start = 1'b1;
		r.op    = op;
		r.neg   = neg;
		r.a     = a;
		r.b     = b;
		return r;
	endfunction

	state_t             state_q;
	logic [19:0]        bw_q;
	logic signed [31:0] pg_q;
	logic [46:0]        lim_q;
	logic [21:0]        g1_q;
	logic [41:0]        g2_q;
	logic [59:0]        g3_q;
	logic signed [47:0] z1_q;
	logic signed [47:0] z2_q;
	logic signed [47:0] z3_q;
	logic signed [48:0] e_q;
	logic signed [31:0] drive_q;
	logic [23:0]        dt_q;
	logic signed [47:0] d1_q;
	logic signed [47:0] d2_q;
	logic signed [47:0] d3_q;
	logic               upd_q;
	mul_req_t           mreq_q;
	mul_rsp_t           mrsp;
	logic               result_valid_q;
	out_item_t          result_q;

	logic               item_fire;
	logic               cfg_fire;
	logic [48:0]        e_mag;
	logic [31:0]        pg_mag;
	logic [31:0]        drive_mag;
	logic signed [47:0] lim_s;
	logic [39:0]        sq;

	assign cfg_ready  = (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign item_fire  = item_valid && !item_stall;

	assign e_mag     = e_q[48] ? (49'd0 - e_q) : e_q;
	assign pg_mag    = pg_q[31] ? (32'd0 - pg_q) : pg_q;
	assign drive_mag = drive_q[31] ? (32'd0 - drive_q) : drive_q;
	assign lim_s     = $signed({1'b0, lim_q});
	assign sq        = mrsp.raw[39:0];

	toeso_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			bw_q           <= BW_RST;
			pg_q           <= PG_RST;
			lim_q          <= '0;
			g1_q           <= G1_RST;
			g2_q           <= G2_RST;
			g3_q           <= G3_RST;
			z1_q           <= '0;
			z2_q           <= '0;
			z3_q           <= '0;
			e_q            <= '0;
			drive_q        <= '0;
			dt_q           <= '0;
			d1_q           <= '0;
			d2_q           <= '0;
			d3_q           <= '0;
			upd_q          <= 1'b0;
			mreq_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			mreq_q.start <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_fire) begin
						unique case (cfg_index)
							CFG_BANDWIDTH: begin
								bw_q    <= cfg_data[19:0];
								g1_q    <= {2'b0, cfg_data[19:0]} + {1'b0, cfg_data[19:0], 1'b0};
								mreq_q  <= mk_req(MOP_GAIN, MUL_AW'(cfg_data[19:0]),
										MUL_BW'(cfg_data[19:0]), 1'b0);
								state_q <= S_GSQ;
							end
							CFG_PLANT_GAIN: pg_q  <= $signed(cfg_data[31:0]);
							CFG_DIST_LIMIT: lim_q <= cfg_data[46:0];
							default: ;
						endcase
					end else if (item_fire) begin
						upd_q   <= 1'b0;
						state_q <= S_OUT;
						if (item.op) begin
							z1_q <= '0;
							z2_q <= '0;
							z3_q <= '0;
						end else if (item.elapsed_time != '0) begin
							e_q     <= $signed({z1_q[47], z1_q})
								- $signed({{9{item.measurement[31]}}, item.measurement, 8'b0});
							drive_q <= item.drive;
							dt_q    <= item.elapsed_time;
							upd_q   <= 1'b1;
							state_q <= S_ERR;
						end
					end
				end
				S_GSQ: begin
					if (mrsp.done) begin
						g2_q    <= {2'b0, sq} + {1'b0, sq, 1'b0};
						mreq_q  <= mk_req(MOP_GAIN, MUL_AW'(sq), MUL_BW'(bw_q), 1'b0);
						state_q <= S_GCUBE;
					end
				end
				S_GCUBE: begin
					if (mrsp.done) begin
						g3_q    <= mrsp.raw;
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					mreq_q  <= mk_req(MOP_G1, e_mag, MUL_BW'(g1_q), e_q[48]);
					state_q <= S_MG1;
				end
				S_MG1: begin
					if (mrsp.done) begin
						d1_q    <= sat48(sx50(z2_q) - sx50(mrsp.prod));
						mreq_q  <= mk_req(MOP_G2, e_mag, MUL_BW'(g2_q), e_q[48]);
						state_q <= S_MG2;
					end
				end
				S_MG2: begin
					if (mrsp.done) begin
						d2_q    <= mrsp.prod;
						mreq_q  <= mk_req(MOP_BU, MUL_AW'(pg_mag), MUL_BW'(drive_mag),
								pg_q[31] ^ drive_q[31]);
						state_q <= S_MBU;
					end
				end
				S_MBU: begin
					if (mrsp.done) begin
						d2_q    <= sat48(sx50(z3_q) - sx50(d2_q) + sx50(mrsp.prod));
						mreq_q  <= mk_req(MOP_G3, e_mag, g3_q, e_q[48]);
						state_q <= S_MG3;
					end
				end
				S_MG3: begin
					if (mrsp.done) begin
						d3_q    <= sat48(-sx50(mrsp.prod));
						mreq_q  <= mk_req(MOP_DT, MUL_AW'(mag48(d1_q)), MUL_BW'(dt_q), d1_q[47]);
						state_q <= S_MD1;
					end
				end
				S_MD1: begin
					if (mrsp.done) begin
						z1_q    <= sat48(sx50(z1_q) + sx50(mrsp.prod));
						mreq_q  <= mk_req(MOP_DT, MUL_AW'(mag48(d2_q)), MUL_BW'(dt_q), d2_q[47]);
						state_q <= S_MD2;
					end
				end
				S_MD2: begin
					if (mrsp.done) begin
						z2_q    <= sat48(sx50(z2_q) + sx50(mrsp.prod));
						mreq_q  <= mk_req(MOP_DT, MUL_AW'(mag48(d3_q)), MUL_BW'(dt_q), d3_q[47]);
						state_q <= S_MD3;
					end
				end
				S_MD3: begin
					if (mrsp.done) begin
						z3_q    <= sat48(sx50(z3_q) + sx50(mrsp.prod));
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (lim_q != '0) begin
						if (z3_q > lim_s) begin
							z3_q <= lim_s;
						end else if (z3_q < -lim_s) begin
							z3_q <= -lim_s;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.estimated_output      <= z1_q;
						result_q.estimated_rate        <= z2_q;
						result_q.estimated_disturbance <= z3_q;
						result_q.updated               <= upd_q;
						result_valid_q                 <= 1'b1;
						state_q                        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TOESO_ASSERT_NEXT(a_item_busy, item_valid && !item_stall, state_q != S_IDLE, "accepted request left the sequencer idle")
	`TOESO_ASSERT_NOW(a_done_waited, mrsp.done, state_q == S_GSQ || state_q == S_GCUBE || state_q == S_MG1 || state_q == S_MG2 || state_q == S_MBU || state_q == S_MG3 || state_q == S_MD1 || state_q == S_MD2 || state_q == S_MD3, "product arrived with no step waiting")
	`TOESO_ASSERT_NOW(a_result_from_out, $rose(result_valid_q), $past(state_q) == S_OUT, "result raised outside the output step")

endmodule
